// ===== sv/rlim_pkg.sv =====
// Shared types and constants for the multi-bucket token rate limiter.
// No dependencies; every other file imports this package.
package rlim_pkg;

  localparam int NUM_COND    = 8;
  localparam int NUM_SLOTS   = NUM_COND + 1;
  localparam int SLOT_W      = 4;
  localparam int MASK_W      = 8;
  localparam int SEL_W       = 3;
  localparam int TIME_W      = 32;
  localparam int TOKEN_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  // Bucket slots: conditions first, then the global bucket; free pass has no slot
  localparam logic [SLOT_W-1:0] SLOT_GLOBAL = SLOT_W'(NUM_COND);
  localparam logic [SLOT_W-1:0] SLOT_FREE   = SLOT_W'(NUM_COND + 1);

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_FILL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COND_SELECT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COND_MAX        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COND_FILL       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COND_INTERVAL   = 3'd7;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Classified operation handed from the front to the back
  typedef struct packed {
    logic              tick;
    logic              glb_en;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now_ms;
  } op_t;

endpackage

// ===== sv/rlim_if.sv =====
// Valid/ready channel interfaces for requests in and decisions out.
// Depends on rlim_pkg for field widths.
interface rlim_in_if import rlim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [MASK_W-1:0] match_mask;
  logic [TIME_W-1:0] now_ms;

  modport source(output valid, command, match_mask, now_ms, input ready);
  modport sink(input valid, command, match_mask, now_ms, output ready);
endinterface

interface rlim_out_if import rlim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              allowed;
  logic [SLOT_W-1:0] decided_by;

  modport source(output valid, allowed, decided_by, input ready);
  modport sink(input valid, allowed, decided_by, output ready);
endinterface

// ===== sv/rlim_front.sv =====
// Front end: accepts requests and ticks and resolves which bucket decides.
// Depends on rlim_pkg and rlim_in_if; holds the global enable register.
module rlim_front import rlim_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  rlim_in_if.sink items,
  output op_t     op,
  output logic    op_valid,
  input  logic    op_ready
);

  localparam int SCAN = (NUM_COND < MASK_W) ? NUM_COND : MASK_W;

  logic              global_enable;
  logic              hit;
  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_enable <= 1'b0;
    end else if (cfg.we && cfg.index == REG_GLOBAL_ENABLE) begin
      global_enable <= cfg.data[0];
    end
  end

  // Lowest matching condition wins; otherwise fall back to global or free pass
  always_comb begin
    hit  = 1'b0;
    slot = SLOT_FREE;
    for (int i = SCAN - 1; i >= 0; i--) begin
      if (items.match_mask[i]) begin
        hit  = 1'b1;
        slot = SLOT_W'(i);
      end
    end
    if (!hit) begin
      slot = global_enable ? SLOT_GLOBAL : SLOT_FREE;
    end
  end

  assign op.tick     = (items.command == CMD_TICK);
  assign op.glb_en   = global_enable;
  assign op.slot     = slot;
  assign op.now_ms   = items.now_ms;
  assign op_valid    = items.valid;
  assign items.ready = op_ready;

endmodule

// ===== sv/rlim_queue.sv =====
// Short FIFO of classified operations between front and back.
// Depends on rlim_pkg for op_t and the queue depth.
module rlim_queue import rlim_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  op_t  push_data,
  input  logic push_valid,
  output logic push_ready,
  output op_t  pop_data,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/rlim_back.sv =====
// Back end: bucket state, token spending, tick walk and the result register.
// Depends on rlim_pkg and rlim_out_if; owns all per-bucket configuration.
module rlim_back import rlim_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  op_t        op,
  input  logic       op_valid,
  output logic       op_ready,
  rlim_out_if.source results
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic               st;
  logic [SEL_W-1:0]   cond_select;
  logic [TOKEN_W-1:0] max_tok  [NUM_SLOTS];
  logic [TOKEN_W-1:0] fill_amt [NUM_SLOTS];
  logic [TIME_W-1:0]  intv     [NUM_SLOTS];
  logic [TOKEN_W-1:0] tok      [NUM_SLOTS];
  logic [TIME_W-1:0]  last     [NUM_SLOTS];

  logic [SLOT_W-1:0]  walk_idx;
  logic [SLOT_W-1:0]  walk_last;
  logic [TIME_W-1:0]  walk_now;

  logic               res_valid;
  logic               res_allowed;
  logic [SLOT_W-1:0]  res_dec;

  logic               out_free;
  logic               take;
  logic [SLOT_W-1:0]  rd_idx;
  logic [TOKEN_W-1:0] cur_tok;
  logic [TIME_W-1:0]  elapsed;
  logic               due;
  logic [TOKEN_W:0]   fill_sum;
  logic [TOKEN_W-1:0] fill_tok;
  logic               is_free;
  logic               sel_ok;
  logic [SLOT_W-1:0]  sel_idx;

  assign out_free = !res_valid || results.ready;
  assign op_ready = (st == ST_IDLE) && (op.tick || out_free);
  assign take     = op_valid && op_ready;
  assign is_free  = (op.slot >= SLOT_W'(NUM_SLOTS));

  // One bucket is read per cycle: the walk slot or the request's slot
  always_comb begin
    if (st == ST_WALK) begin
      rd_idx = walk_idx;
    end else if (is_free) begin
      rd_idx = SLOT_GLOBAL;
    end else begin
      rd_idx = op.slot;
    end
  end

  assign cur_tok  = tok[rd_idx];
  assign elapsed  = walk_now - last[rd_idx];
  assign due      = (elapsed >= intv[rd_idx]);
  assign fill_sum = {1'b0, cur_tok} + {1'b0, fill_amt[rd_idx]};
  assign fill_tok = (fill_sum > {1'b0, max_tok[rd_idx]}) ? max_tok[rd_idx]
                                                         : fill_sum[TOKEN_W-1:0];

  assign sel_ok  = (int'(cond_select) < NUM_COND);
  assign sel_idx = SLOT_W'(cond_select);

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      cond_select <= '0;
      walk_idx    <= '0;
      walk_last   <= '0;
      walk_now    <= '0;
      res_valid   <= 1'b0;
      res_allowed <= 1'b0;
      res_dec     <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        max_tok[i]  <= '0;
        fill_amt[i] <= TOKEN_W'(1);
        intv[i]     <= TIME_W'(1000);
        tok[i]      <= '0;
        last[i]     <= '0;
      end
    end else begin
      if (take && !op.tick) begin
        res_valid <= 1'b1;
        res_dec   <= op.slot;
        if (is_free) begin
          res_allowed <= 1'b1;
        end else begin
          res_allowed <= (cur_tok != '0);
          if (cur_tok != '0) begin
            tok[rd_idx] <= cur_tok - 1'b1;
          end
        end
      end else if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end

      // Start a tick walk; skip the global bucket when it is disabled
      if (take && op.tick) begin
        st        <= ST_WALK;
        walk_idx  <= '0;
        walk_now  <= op.now_ms;
        walk_last <= op.glb_en ? SLOT_GLOBAL : SLOT_W'(NUM_COND - 1);
      end

      if (st == ST_WALK) begin
        if (due) begin
          tok[rd_idx]  <= fill_tok;
          last[rd_idx] <= walk_now;
        end
        if (walk_idx == walk_last) begin
          st <= ST_IDLE;
        end else begin
          walk_idx <= walk_idx + 1'b1;
        end
      end

      if (cfg.we) begin
        case (cfg.index)
          REG_GLOBAL_MAX: begin
            max_tok[SLOT_GLOBAL] <= cfg.data[TOKEN_W-1:0];
            tok[SLOT_GLOBAL]     <= cfg.data[TOKEN_W-1:0];
          end
          REG_GLOBAL_FILL:     fill_amt[SLOT_GLOBAL] <= cfg.data[TOKEN_W-1:0];
          REG_GLOBAL_INTERVAL: intv[SLOT_GLOBAL]     <= cfg.data[TIME_W-1:0];
          REG_COND_SELECT:     cond_select           <= cfg.data[SEL_W-1:0];
          REG_COND_MAX: begin
            if (sel_ok) begin
              max_tok[sel_idx] <= cfg.data[TOKEN_W-1:0];
              tok[sel_idx]     <= cfg.data[TOKEN_W-1:0];
            end
          end
          REG_COND_FILL: begin
            if (sel_ok) begin
              fill_amt[sel_idx] <= cfg.data[TOKEN_W-1:0];
            end
          end
          REG_COND_INTERVAL: begin
            if (sel_ok) begin
              intv[sel_idx] <= cfg.data[TIME_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign results.valid      = res_valid;
  assign results.allowed    = res_allowed;
  assign results.decided_by = res_dec;

endmodule

// ===== sv/multi_bucket_token_rate_limiter.sv =====
// Request path: the queue registers an accepted request, then the back end registers its decision.
// Throughput: one request per cycle while no tick walk runs and the decision is not stalled; a tick
// walk visits each condition bucket, then the global bucket when enabled, one bucket per cycle.
// The 2-entry queue accepts up to two items while a tick walk is in progress.
// Reset (synchronous, active high) restores all buckets and registers at once.
module multi_bucket_token_rate_limiter import rlim_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rlim_in_if.sink               items,
  rlim_out_if.source            results
);

  cfg_wr_t cfg;
  op_t     front_op;
  logic    front_valid;
  logic    front_ready;
  op_t     back_op;
  logic    back_valid;
  logic    back_ready;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  rlim_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .items    (items),
    .op       (front_op),
    .op_valid (front_valid),
    .op_ready (front_ready)
  );

  rlim_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_op),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  rlim_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (back_op),
    .op_valid (back_valid),
    .op_ready (back_ready),
    .results  (results)
  );

endmodule

// ===== sv/rlim_checker.sv =====
// Port-level checks for the rate limiter, attached to the top level by bind.
// Depends on rlim_pkg for the decision codes.
module rlim_checker import rlim_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_allowed,
  input logic [SLOT_W-1:0] res_dec
);

  // Hold a stalled decision
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_dec) && $stable(res_allowed))
    else $error("stalled decision changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_dec <= SLOT_FREE)
    else $error("decision code out of range");

  a_free: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_dec == SLOT_FREE |-> res_allowed)
    else $error("free pass denied");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("decision pending after reset");

endmodule

bind multi_bucket_token_rate_limiter rlim_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .res_allowed (results.allowed),
  .res_dec     (results.decided_by)
);
